@@ rtl/sbd_pkg.sv @@
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared types and constant tables for the serial baud divider search.
// ----------------------------------------------------------------------------
`default_nettype none

package sbd_pkg;

  localparam int unsigned HzW    = 32;
  localparam int unsigned DivW   = 18;  // largest divisor 32768 * 7 fits 18 bits
  localparam int unsigned SclIdW = 4;
  localparam int unsigned PreIdW = 2;
  localparam int unsigned BitCntW = 5;  // counts the quotient bits

  localparam logic [SclIdW-1:0] SclLast = 4'd15;
  localparam logic [PreIdW-1:0] PreLast = 2'd3;

  localparam logic [15:0] ScalerTab [16] = '{
    16'd2,    16'd4,    16'd6,    16'd8,    16'd16,   16'd32,   16'd64,   16'd128,
    16'd256,  16'd512,  16'd1024, 16'd2048, 16'd4096, 16'd8192, 16'd16384, 16'd32768
  };

  localparam logic [2:0] PrescTab [4] = '{3'd2, 3'd3, 3'd5, 3'd7};

  // request to the serial divider
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] divisor;
  } div_req_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [DivW-1:0] divisor_of(input logic [PreIdW-1:0] p,
                                                 input logic [SclIdW-1:0] s);
    logic [DivW-1:0] scl;
    logic [DivW-1:0] pre;
    scl = DivW'(ScalerTab[s]);
    pre = DivW'(PrescTab[p]);
    return DivW'(scl * pre);
  endfunction

endpackage

`default_nettype wire

@@ rtl/sbd_serial_div.sv @@
// ----------------------------------------------------------------------------
// sbd_serial_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_serial_div (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire  sbd_pkg::div_req_t  req_i,
  input  wire  [sbd_pkg::HzW-1:0]  dividend_i,
  output sbd_pkg::div_stat_t       stat_o,
  output logic [sbd_pkg::HzW-1:0]  quotient_o
);
  import sbd_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    rem_q, rem_d;
  logic [HzW-1:0]     quo_q, quo_d;
  logic [DivW-1:0]    dsr_q, dsr_d;
  logic [DivW:0]      trial;
  logic               ge;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[HzW-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? DivW'(trial - {1'b0, dsr_q}) : trial[DivW-1:0];
      quo_d = {quo_q[HzW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

`default_nettype wire

@@ rtl/spi_baud_divider_search.sv @@
// ----------------------------------------------------------------------------
// spi_baud_divider_search
// Walks prescaler/scaler pairs through a bit-serial divider and keeps the
// fastest serial clock not above the target.
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-------------------------------------
//  in      | in_valid_i  | in_stall_o  | module_hz_i, target_hz_i
//  out     | out_valid_o | out_stall_i | found_o, scaler_index_o,
//          |             |             | prescaler_index_o
//
//  one word at a time; each pair tried runs a start, the quotient bits in the
//  serial divider and a compare, and up to 64 pairs are tried per word
//  in_stall_o is high from accept until the result is handed to the output
//  register; a stalled output holds the search in its final state
//  asynchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module spi_baud_divider_search (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [sbd_pkg::HzW-1:0]      module_hz_i,
  input  wire  [sbd_pkg::HzW-1:0]      target_hz_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         found_o,
  output logic [sbd_pkg::SclIdW-1:0]   scaler_index_o,
  output logic [sbd_pkg::PreIdW-1:0]   prescaler_index_o
);
  import sbd_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [HzW-1:0]    module_q, module_d;
  logic [HzW-1:0]    target_q, target_d;
  logic [PreIdW-1:0] pre_q, pre_d;
  logic [SclIdW-1:0] scl_q, scl_d;
  logic              have_q, have_d;
  logic [HzW-1:0]    best_q, best_d;
  logic [SclIdW-1:0] best_scl_q, best_scl_d;
  logic [PreIdW-1:0] best_pre_q, best_pre_d;
  logic              out_valid_q, out_valid_d;
  logic              found_q, found_d;
  logic [SclIdW-1:0] out_scl_q, out_scl_d;
  logic [PreIdW-1:0] out_pre_q, out_pre_d;

  div_req_t          div_req;
  div_stat_t         div_stat;
  logic [HzW-1:0]    freq;
  logic              qual;
  logic              better;
  logic              in_acc;
  logic              out_free;

  sbd_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (module_q),
    .stat_o     (div_stat),
    .quotient_o (freq)
  );

  assign div_req.start   = (state_q == S_START);
  assign div_req.divisor = divisor_of(pre_q, scl_q);

  assign qual     = freq <= target_q;
  assign better   = !have_q || (freq > best_q);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    module_d    = module_q;
    target_d    = target_q;
    pre_d       = pre_q;
    scl_d       = scl_q;
    have_d      = have_q;
    best_d      = best_q;
    best_scl_d  = best_scl_q;
    best_pre_d  = best_pre_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    out_scl_d   = out_scl_q;
    out_pre_d   = out_pre_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          module_d   = module_hz_i;
          target_d   = target_hz_i;
          pre_d      = '0;
          scl_d      = '0;
          have_d     = 1'b0;
          best_d     = '0;
          best_scl_d = '0;
          best_pre_d = '0;
          state_d    = S_START;
        end
      end
      S_START: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_stat.done) begin
          if (qual && better) begin
            have_d     = 1'b1;
            best_d     = freq;
            best_scl_d = scl_q;
            best_pre_d = pre_q;
          end
          // first qualifying scaler ends this prescaler's scan
          if (qual || scl_q == SclLast) begin
            scl_d = '0;
            if (pre_q == PreLast) begin
              state_d = S_DONE;
            end else begin
              pre_d   = pre_q + 1'b1;
              state_d = S_START;
            end
          end else begin
            scl_d   = scl_q + 1'b1;
            state_d = S_START;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = have_q;
          out_scl_d   = have_q ? best_scl_q : '0;
          out_pre_d   = have_q ? best_pre_q : '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      have_q      <= 1'b0;
      pre_q       <= '0;
      scl_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      have_q      <= have_d;
      pre_q       <= pre_d;
      scl_q       <= scl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    module_q   <= module_d;
    target_q   <= target_d;
    best_q     <= best_d;
    best_scl_q <= best_scl_d;
    best_pre_q <= best_pre_d;
    found_q    <= found_d;
    out_scl_q  <= out_scl_d;
    out_pre_q  <= out_pre_d;
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign found_o           = found_q;
  assign scaler_index_o    = out_scl_q;
  assign prescaler_index_o = out_pre_q;

  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_WAIT)
    else $error("divider finished outside the wait state");

  a_div_idle_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> !div_stat.busy)
    else $error("divider still busy after the search ended");

  a_best_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q && state_q != S_IDLE |-> best_q <= target_q)
    else $error("kept frequency above the target");

  a_notfound_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> scaler_index_o == '0 && prescaler_index_o == '0)
    else $error("indices nonzero without a solution");

endmodule

`default_nettype wire
